// File: rtl/ghp_pkg.sv
// ============================================================================
// ghp_pkg
// Shared sizes, codes and handle helpers of the generational handle pool.
// ============================================================================
package ghp_pkg;

	localparam int CAPACITY  = 1024;
	localparam int SLOT_BITS = 16;
	localparam int GEN_BITS  = 16;

	localparam int HANDLE_W = 32;
	localparam int POS_W    = 10;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [63:0] SLOT_MASK = (64'd1 << SLOT_BITS) - 64'd1;
	localparam logic [63:0] GEN_MASK  = (64'd1 << GEN_BITS) - 64'd1;

	typedef logic [HANDLE_W-1:0] handle_word_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		KIND_ALLOC    = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_VALIDATE = 2'd2,
		KIND_READ     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_FULL   = 2'd1,
		ERR_HANDLE = 2'd2,
		ERR_RANGE  = 2'd3
	} err_t;

	function automatic handle_word_t make_handle(logic [63:0] gen, logic [63:0] slot);
		logic [63:0] h;
		h = ((gen & GEN_MASK) << SLOT_BITS) | (slot & SLOT_MASK);
		return h[HANDLE_W-1:0];
	endfunction

	function automatic logic [63:0] slot_of(handle_word_t h);
		return {{(64-HANDLE_W){1'b0}}, h} & SLOT_MASK;
	endfunction

	function automatic logic [63:0] gen_of(handle_word_t h);
		return ({{(64-HANDLE_W){1'b0}}, h} >> SLOT_BITS) & GEN_MASK;
	endfunction

endpackage

// File: rtl/ghp_req_if.sv
// ============================================================================
// ghp_req_if
// Request channel of the handle pool: kind, handle and position.
// ============================================================================
interface ghp_req_if;

	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	ghp_pkg::handle_word_t     handle_in;
	logic [ghp_pkg::POS_W-1:0] position;

	modport source (output valid, output kind, output handle_in, output position,
		input ready);
	modport sink (input valid, input kind, input handle_in, input position,
		output ready);

endinterface

// File: rtl/ghp_rsp_if.sv
// ============================================================================
// ghp_rsp_if
// Response channel of the handle pool: one transaction per request.
// ============================================================================
interface ghp_rsp_if;

	logic                  valid;
	logic                  ready;
	ghp_pkg::handle_word_t handle_out;
	logic                  is_valid;
	logic [1:0]            error_code;
	ghp_pkg::cnt_t         live_count;
	logic                  full_res;

	modport source (output valid, output handle_out, output is_valid,
		output error_code, output live_count, output full_res, input ready);
	modport sink (input valid, input handle_out, input is_valid,
		input error_code, input live_count, input full_res, output ready);

endinterface

// File: rtl/ghp_ram.sv
// ============================================================================
// ghp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ghp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/generational_handle_pool.sv
// ============================================================================
// generational_handle_pool
// Pool of generational handles kept as a sparse set in two RAMs.
// ============================================================================
// Requests arrive on req (kind, handle_in, position) and each gives exactly
// one response transaction on rsp (handle_out, is_valid, error_code,
// live_count, full_res). Both channels use a valid/ready handshake.
// The pool takes one request at a time; req.ready is high while it waits
// for work. An allocate on a full pool goes straight to the response; an
// allocate or read-at reads the dense RAM; a validate or a remove reads the
// sparse RAM, then the dense RAM. The next request is taken once the
// response is registered. The sequence is set by the single read port of
// each RAM and its registered read data: a remove reads the sparse RAM,
// then the dense RAM twice, then writes the dense RAM twice.
// Reset clears the live count and a high-water mark. Dense entries at or
// above the mark read as their reset handle and sparse entries at or above
// it read as zero, so there is no clearing pass; the first request may be
// taken right after reset. When the receiver stalls, the response is held
// and the pool keeps the finished request parked until rsp is taken.
// ============================================================================
module generational_handle_pool (
	input  logic          clk,
	input  logic          arst_n,
	ghp_req_if.sink       req,
	ghp_rsp_if.source     rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPARSE,
		ST_DENSE,
		ST_LAST,
		ST_SWAP,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	ghp_pkg::cnt_t          count_q;
	ghp_pkg::cnt_t          hwm_q;
	ghp_pkg::kind_t         kind_q;
	ghp_pkg::handle_word_t  h_q;
	ghp_pkg::cnt_t          position_q;
	ghp_pkg::addr_t         pos_q;
	ghp_pkg::handle_word_t  last_q;
	ghp_pkg::addr_t         dense_ra_q;
	ghp_pkg::addr_t         sparse_ra_q;
	ghp_pkg::handle_word_t  res_handle_q;
	logic                   res_valid_q;
	ghp_pkg::err_t          res_err_q;

	logic                   rsp_valid_q;
	ghp_pkg::handle_word_t  rsp_handle_q;
	logic                   rsp_is_valid_q;
	ghp_pkg::err_t          rsp_err_q;
	ghp_pkg::cnt_t          rsp_count_q;

	logic                   d_we;
	ghp_pkg::addr_t         d_waddr;
	ghp_pkg::handle_word_t  d_wdata;
	ghp_pkg::addr_t         d_raddr;
	ghp_pkg::handle_word_t  d_rdata;
	logic                   s_we;
	ghp_pkg::addr_t         s_waddr;
	ghp_pkg::addr_t         s_wdata;
	ghp_pkg::addr_t         s_raddr;
	ghp_pkg::addr_t         s_rdata;

	ghp_pkg::handle_word_t  dense_val;
	ghp_pkg::addr_t         sparse_val;
	ghp_pkg::handle_word_t  new_h;
	ghp_pkg::cnt_t          last_pos;
	logic                   live;
	logic                   pool_full;

	ghp_ram #(.WIDTH(ghp_pkg::HANDLE_W), .DEPTH(ghp_pkg::CAPACITY)) u_dense (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	ghp_ram #(.WIDTH(ghp_pkg::ADDR_W), .DEPTH(ghp_pkg::CAPACITY)) u_sparse (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.handle_out = rsp_handle_q;
	assign rsp.is_valid   = rsp_is_valid_q;
	assign rsp.error_code = rsp_err_q;
	assign rsp.live_count = rsp_count_q;
	assign rsp.full_res   = (rsp_count_q == ghp_pkg::cnt_t'(ghp_pkg::CAPACITY));

	assign pool_full = (count_q == ghp_pkg::cnt_t'(ghp_pkg::CAPACITY));
	assign last_pos  = count_q - ghp_pkg::cnt_t'(1);

	always_comb begin
		if (ghp_pkg::cnt_t'(dense_ra_q) >= hwm_q) begin
			dense_val = ghp_pkg::make_handle(64'd0, 64'(dense_ra_q));
		end else begin
			dense_val = d_rdata;
		end
		if (ghp_pkg::cnt_t'(sparse_ra_q) >= hwm_q) begin
			sparse_val = '0;
		end else begin
			sparse_val = s_rdata;
		end
		new_h = ghp_pkg::make_handle(ghp_pkg::gen_of(dense_val) + 64'd1,
			ghp_pkg::slot_of(dense_val));
		live = (ghp_pkg::slot_of(h_q) < 64'(ghp_pkg::CAPACITY))
			&& (ghp_pkg::cnt_t'(pos_q) < count_q) && (dense_val == h_q);
	end

	always_comb begin
		d_we    = 1'b0;
		d_waddr = pos_q;
		d_wdata = last_q;
		d_raddr = dense_ra_q;
		s_we    = 1'b0;
		s_waddr = ghp_pkg::addr_t'(ghp_pkg::slot_of(dense_val));
		s_wdata = pos_q;
		s_raddr = sparse_ra_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (ghp_pkg::kind_t'(req.kind))
						ghp_pkg::KIND_ALLOC: d_raddr = count_q[ghp_pkg::ADDR_W-1:0];
						ghp_pkg::KIND_READ:  d_raddr = ghp_pkg::addr_t'(req.position);
						default: s_raddr = ghp_pkg::addr_t'(ghp_pkg::slot_of(req.handle_in));
					endcase
				end
			end
			ST_SPARSE: begin
				d_raddr = sparse_val;
			end
			ST_DENSE: begin
				if (kind_q == ghp_pkg::KIND_ALLOC) begin
					d_we    = 1'b1;
					d_waddr = count_q[ghp_pkg::ADDR_W-1:0];
					d_wdata = new_h;
					s_we    = (ghp_pkg::slot_of(dense_val) < 64'(ghp_pkg::CAPACITY));
					s_wdata = count_q[ghp_pkg::ADDR_W-1:0];
				end else if (kind_q == ghp_pkg::KIND_REMOVE && live) begin
					d_raddr = last_pos[ghp_pkg::ADDR_W-1:0];
				end
			end
			ST_LAST: begin
				d_we    = 1'b1;
				d_waddr = last_pos[ghp_pkg::ADDR_W-1:0];
				d_wdata = h_q;
				s_we    = (ghp_pkg::slot_of(dense_val) < 64'(ghp_pkg::CAPACITY));
			end
			ST_SWAP: begin
				d_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			hwm_q          <= '0;
			kind_q         <= ghp_pkg::KIND_ALLOC;
			h_q            <= '0;
			position_q     <= '0;
			pos_q          <= '0;
			last_q         <= '0;
			dense_ra_q     <= '0;
			sparse_ra_q    <= '0;
			res_handle_q   <= '0;
			res_valid_q    <= 1'b0;
			res_err_q      <= ghp_pkg::ERR_NONE;
			rsp_valid_q    <= 1'b0;
			rsp_handle_q   <= '0;
			rsp_is_valid_q <= 1'b0;
			rsp_err_q      <= ghp_pkg::ERR_NONE;
			rsp_count_q    <= '0;
		end else begin
			dense_ra_q  <= d_raddr;
			sparse_ra_q <= s_raddr;
			if (state_q == ST_EMIT && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						kind_q       <= ghp_pkg::kind_t'(req.kind);
						h_q          <= req.handle_in;
						position_q   <= ghp_pkg::cnt_t'(req.position);
						res_handle_q <= '0;
						res_valid_q  <= 1'b0;
						res_err_q    <= (ghp_pkg::kind_t'(req.kind) == ghp_pkg::KIND_ALLOC
							&& pool_full) ? ghp_pkg::ERR_FULL : ghp_pkg::ERR_NONE;
						case (ghp_pkg::kind_t'(req.kind))
							ghp_pkg::KIND_ALLOC: begin
								if (pool_full) begin
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_DENSE;
								end
							end
							ghp_pkg::KIND_READ: state_q <= ST_DENSE;
							default: state_q <= ST_SPARSE;
						endcase
					end
				end
				ST_SPARSE: begin
					pos_q   <= sparse_val;
					state_q <= ST_DENSE;
				end
				ST_DENSE: begin
					case (kind_q)
						ghp_pkg::KIND_ALLOC: begin
							res_handle_q <= new_h;
							count_q      <= count_q + ghp_pkg::cnt_t'(1);
							state_q      <= ST_EMIT;
							if (count_q == hwm_q) begin
								hwm_q <= hwm_q + ghp_pkg::cnt_t'(1);
							end
						end
						ghp_pkg::KIND_READ: begin
							state_q <= ST_EMIT;
							if (position_q < count_q) begin
								res_handle_q <= dense_val;
							end else begin
								res_err_q <= ghp_pkg::ERR_RANGE;
							end
						end
						ghp_pkg::KIND_VALIDATE: begin
							res_valid_q <= live;
							state_q     <= ST_EMIT;
						end
						default: begin
							if (live) begin
								state_q <= ST_LAST;
							end else begin
								res_err_q <= ghp_pkg::ERR_HANDLE;
								state_q   <= ST_EMIT;
							end
						end
					endcase
				end
				ST_LAST: begin
					last_q  <= dense_val;
					count_q <= last_pos;
					state_q <= ST_SWAP;
				end
				ST_SWAP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_handle_q   <= res_handle_q;
						rsp_is_valid_q <= res_valid_q;
						rsp_err_q      <= res_err_q;
						rsp_count_q    <= count_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ghp_pkg::cnt_t'(ghp_pkg::CAPACITY))
		else $error("live count above capacity");

	a_count_mark: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hwm_q)
		else $error("live count above high-water mark");

	a_write_mark: assert property (@(posedge clk) disable iff (!arst_n)
		d_we |-> ghp_pkg::cnt_t'(d_waddr) <= hwm_q)
		else $error("dense write beyond high-water mark");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != ST_IDLE)
		else $error("accepted transaction not in progress");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && (!rsp_valid_q || rsp.ready)
		|=> rsp_valid_q && state_q == ST_IDLE)
		else $error("response transaction not issued");
`endif

endmodule
